FILE: design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the TS continuity counter checker.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned PID_W = 13;
  localparam int unsigned CC_W  = 4;
  localparam int unsigned ERR_W = 32;

  localparam logic [PID_W-1:0] PID_NULL = 13'h1fff;
  localparam logic [PID_W-1:0] PID_SKIP = 13'h00ff;

  typedef enum logic [1:0] {
    AFC_RESERVED = 2'd0,
    AFC_PAYLOAD  = 2'd1,
    AFC_ADAPT    = 2'd2,
    AFC_BOTH     = 2'd3
  } afc_e;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_OK      = 3'd3,
    ST_ERROR   = 3'd4
  } status_e;

  // classified header, front to back
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    afc_e             afc;
    logic             dis;
    logic             ignore;
  } item_t;

  // one tracked PID
  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    logic             dis;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic [ERR_W-1:0] error_total;
  } res_t;

endpackage

FILE: design/ts_continuity_counter_checker_core.sv
// ----------------------------------------------------------------------------
// ts_continuity_counter_checker_core
// Continuity counter check of MPEG-TS packet headers over a table of PIDs.
// ----------------------------------------------------------------------------
// Headers enter a two-entry queue and are handled one at a time by the table
// engine, which scans the PID table memory one entry per cycle. An ignored
// PID is answered as it leaves the queue, a tracked PID when the scan
// reaches its entry, a new PID (or a full table) after the occupied entries
// are all scanned. The table needs no clearing after reset: a fill count
// marks the occupied entries. Results wait in a two-entry output queue.
module ts_continuity_counter_checker_core #(
  parameter int unsigned TABLE_ENTRIES = tcc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [tcc_pkg::PID_W-1:0] packet_pid_i,
  input  logic [tcc_pkg::CC_W-1:0]  cont_count_i,
  input  logic [1:0]                adapt_ctrl_i,
  input  logic                      discont_flag_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                check_status_o,
  output logic [tcc_pkg::ERR_W-1:0] error_total_o
);

  logic                             mid_valid;
  tcc_pkg::item_t                   mid_item;
  logic                             mid_pop;
  logic                             res_push;
  logic                             res_full;
  tcc_pkg::res_t                    res;
  logic [$bits(tcc_pkg::res_t)-1:0] out_data;
  tcc_pkg::res_t                    out_res;

  tcc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .packet_pid_i   (packet_pid_i),
    .cont_count_i   (cont_count_i),
    .adapt_ctrl_i   (adapt_ctrl_i),
    .discont_flag_i (discont_flag_i),
    .full_o         (full),
    .item_valid_o   (mid_valid),
    .item_o         (mid_item),
    .item_pop_i     (mid_pop)
  );

  tcc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (mid_valid),
    .item_i       (mid_item),
    .item_pop_o   (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  tcc_fifo #(
    .WIDTH ($bits(tcc_pkg::res_t)),
    .DEPTH (tcc_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_res        = tcc_pkg::res_t'(out_data);
  assign check_status_o = out_res.status;
  assign error_total_o  = out_res.error_total;

  // engine never writes into a full result queue
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // an ignored PID is answered in the cycle it leaves the queue
  a_ignored_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_pop && mid_item.ignore) |->
      (res_push && (res.status == tcc_pkg::ST_IGNORED)))
    else $error("ignored PID not answered at once");

  // a pushed result is visible at the output next cycle
  a_res_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty)
    else $error("result lost in output queue");

endmodule

FILE: design/tcc_fifo.sv
// ----------------------------------------------------------------------------
// tcc_fifo
// Small synchronous FIFO used between the checker stages and at the output.
// ----------------------------------------------------------------------------
module tcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tcc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Accepts packet headers, flags ignored PIDs and queues them for the engine.
// ----------------------------------------------------------------------------
module tcc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [tcc_pkg::PID_W-1:0]  packet_pid_i,
  input  logic [tcc_pkg::CC_W-1:0]   cont_count_i,
  input  logic [1:0]                 adapt_ctrl_i,
  input  logic                       discont_flag_i,
  output logic                       full_o,
  output logic                       item_valid_o,
  output tcc_pkg::item_t             item_o,
  input  logic                       item_pop_i
);

  tcc_pkg::item_t                    in_item;
  logic [$bits(tcc_pkg::item_t)-1:0] q_data;
  logic                              q_empty;

  always_comb begin
    in_item.pid    = packet_pid_i;
    in_item.cc     = cont_count_i;
    in_item.afc    = tcc_pkg::afc_e'(adapt_ctrl_i);
    in_item.dis    = discont_flag_i;
    in_item.ignore = (packet_pid_i == tcc_pkg::PID_NULL) ||
                     (packet_pid_i == tcc_pkg::PID_SKIP);
  end

  tcc_fifo #(
    .WIDTH ($bits(tcc_pkg::item_t)),
    .DEPTH (tcc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (in_item),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign item_valid_o = !q_empty;
  assign item_o       = tcc_pkg::item_t'(q_data);

endmodule

FILE: design/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// PID table engine: scans the table memory one entry per cycle, checks the
// continuity counter of a tracked PID, allocates new PIDs, counts errors.
// ----------------------------------------------------------------------------
module tcc_back #(
  parameter int unsigned TABLE_ENTRIES = tcc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  tcc_pkg::item_t item_i,
  output logic           item_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output tcc_pkg::res_t  res_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_MISS = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  tcc_pkg::item_t                 item_q, item_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic [CNT_W-1:0]               fill_q, fill_d;
  logic [tcc_pkg::ERR_W-1:0]      err_q, err_d;

  tcc_pkg::entry_t                tbl_mem_q [TABLE_ENTRIES];
  tcc_pkg::entry_t                rd_entry_q;
  logic [IDX_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  tcc_pkg::entry_t                wr_data;

  logic [tcc_pkg::CC_W-1:0]       next_cc;
  logic [tcc_pkg::CC_W-1:0]       expect_cc;
  logic                           chk;
  logic                           mismatch;
  logic                           hit;
  logic                           last;

  // expected counter of a tracked PID
  always_comb begin
    next_cc = rd_entry_q.cc + tcc_pkg::CC_W'(1);
    unique case (item_q.afc)
      tcc_pkg::AFC_RESERVED: begin
        chk       = 1'b1;
        expect_cc = rd_entry_q.cc;
      end
      tcc_pkg::AFC_PAYLOAD: begin
        chk       = 1'b1;
        expect_cc = next_cc;
      end
      tcc_pkg::AFC_ADAPT: begin
        chk       = !item_q.dis;
        expect_cc = rd_entry_q.cc;
      end
      default: begin
        chk       = !item_q.dis && !rd_entry_q.dis;
        expect_cc = next_cc;
      end
    endcase
    mismatch = chk && (item_q.cc != expect_cc);
  end

  assign hit  = (rd_entry_q.pid == item_q.pid);
  assign last = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    err_d        = err_q;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data.pid  = item_q.pid;
    wr_data.cc   = item_q.cc;
    wr_data.dis  = item_q.dis;
    item_pop_o   = 1'b0;
    res_push_o   = 1'b0;
    res_o.status = tcc_pkg::ST_OK;

    unique case (state_q)
      S_IDLE: begin
        // one item in flight; a free output slot stays free until it is done
        if (item_valid_i && !res_full_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          if (item_i.ignore) begin
            res_push_o   = 1'b1;
            res_o.status = tcc_pkg::ST_IGNORED;
          end else if (fill_q == '0) begin
            state_d = S_MISS;
          end else begin
            state_d = S_SCAN;
            idx_d   = '0;
            rd_addr = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_en      = 1'b1;
          res_push_o = 1'b1;
          state_d    = S_IDLE;
          if (mismatch) begin
            err_d        = err_q + tcc_pkg::ERR_W'(1);
            res_o.status = tcc_pkg::ST_ERROR;
          end else begin
            res_o.status = tcc_pkg::ST_OK;
          end
        end else if (last) begin
          state_d = S_MISS;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          rd_addr = idx_q + IDX_W'(1);
        end
      end
      S_MISS: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
        // entries fill from the bottom and are never freed
        if (fill_q < CNT_W'(TABLE_ENTRIES)) begin
          wr_en        = 1'b1;
          wr_addr      = fill_q[IDX_W-1:0];
          fill_d       = fill_q + CNT_W'(1);
          res_o.status = tcc_pkg::ST_NEW;
        end else begin
          res_o.status = tcc_pkg::ST_FULL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.error_total = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
      err_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_entry_q <= tbl_mem_q[rd_addr];
  end

endmodule
